// ----- src/lagged_fibonacci_xor_generator_assert.svh -----
// Assertion macros shared by the generator RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef LAGGED_FIBONACCI_XOR_GENERATOR_ASSERT_SVH
`define LAGGED_FIBONACCI_XOR_GENERATOR_ASSERT_SVH

// Checks an implication or expression on every rising edge outside reset.
`define LFX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks an expression on every rising edge, reset included.
`define LFX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/lfx_pkg.sv -----
// Package for the lagged Fibonacci XOR generator: sizes, lags and codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package lfx_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SEED_W    = 31;
  localparam int unsigned HIST_LEN  = 61;
  localparam int unsigned LAG_SHORT = 24;
  localparam int unsigned LAG_LONG  = 55;
  localparam int unsigned TAP_SHORT = HIST_LEN - LAG_SHORT;
  localparam int unsigned TAP_LONG  = HIST_LEN - LAG_LONG;
  localparam int unsigned CNT_W     = $clog2(HIST_LEN);
  localparam int unsigned PM_MULT_W = 15;
  localparam int unsigned PROD_W    = SEED_W + PM_MULT_W;

  localparam logic [PM_MULT_W-1:0] PM_MULT  = 15'd16807;
  localparam logic [SEED_W-1:0]    SEED_BAD = 31'h7fffffff;
  localparam logic [CNT_W-1:0]     FILL_LAST = CNT_W'(HIST_LEN - 1);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SEED_W-1:0] seed_t;

  typedef enum logic {
    REQ_RESEED = 1'b0,
    REQ_DRAW   = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STAT_DRAWN    = 2'd0,
    STAT_SEEDED   = 2'd1,
    STAT_REJECTED = 2'd2,
    STAT_NOSEED   = 2'd3
  } status_t;

endpackage

// ----- src/lfx_cell.sv -----
// One word of the history chain: loads its neighbor's word when shifted.
// Depends on lfx_pkg.
`timescale 1ns / 1ps

module lfx_cell (
  input  logic          clk,
  input  logic          shift_en,
  input  lfx_pkg::word_t d,
  output lfx_pkg::word_t q
);

  lfx_pkg::word_t word_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      word_r <= d;
    end
  end

  assign q = word_r;

endmodule

// ----- src/lfx_pm_step.sv -----
// One step of the minimal standard recurrence, s * 16807 mod 2^31-1.
// Depends on lfx_pkg.
`timescale 1ns / 1ps

module lfx_pm_step (
  input  lfx_pkg::seed_t s,
  output lfx_pkg::seed_t s_nxt
);

  logic [lfx_pkg::PROD_W-1:0] prod;
  logic [lfx_pkg::WORD_W-1:0] fold;
  logic [lfx_pkg::WORD_W-1:0] fold_inc;

  always_comb begin
    prod     = lfx_pkg::PROD_W'(s) * lfx_pkg::PROD_W'(lfx_pkg::PM_MULT);
    fold     = lfx_pkg::WORD_W'(prod[lfx_pkg::SEED_W-1:0])
             + lfx_pkg::WORD_W'(prod[lfx_pkg::PROD_W-1:lfx_pkg::SEED_W]);
    fold_inc = {1'b0, fold[lfx_pkg::SEED_W-1:0]} + lfx_pkg::WORD_W'(1);
    s_nxt    = fold[lfx_pkg::WORD_W-1] ? fold_inc[lfx_pkg::SEED_W-1:0]
                                        : fold[lfx_pkg::SEED_W-1:0];
  end

endmodule

// ----- src/lagged_fibonacci_xor_generator.sv -----
// Lagged Fibonacci XOR random word generator, top level.
// Depends on lfx_pkg, lfx_cell, lfx_pm_step and the assertion macro header.
//
// Input channel: in_tuser[0] is the request kind (0 reseed, 1 draw) and
// in_tdata[30:0] the seed. Result channel: out_tdata is the random word
// (zero unless drawn) and out_tuser the status (0 drawn, 1 seeded,
// 2 seed rejected, 3 not seeded). Every transfer in gives one transfer out.
// A result is registered and shows in the cycle after its input transfer.
// Draws and rejected reseeds leave the input ready, so one item per cycle is
// sustained while the receiver keeps up. An accepted reseed runs the
// Park-Miller step 61 times, one per cycle through a single multiplier,
// shifting each word into a chain of 61 history cells; in_tready stays low
// while the chain fills. A draw reads taps of the cell chain, adds and xors,
// and shifts the chain by one cell. After reset the generator is unseeded
// and draws return status 3. When the receiver stalls, the result is held
// and a new item is taken only in the cycle the held result leaves.
`timescale 1ns / 1ps
`include "lagged_fibonacci_xor_generator_assert.svh"

module lagged_fibonacci_xor_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] seed, [31] zero fill
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [1:0]  out_tuser   // [1:0] status
);

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  state_t                    state_r;
  logic [lfx_pkg::CNT_W-1:0] fill_cnt_r;
  lfx_pkg::seed_t            seed_r;
  logic                      seeded_r;
  logic                      out_valid_r;
  lfx_pkg::word_t            out_value_r;
  lfx_pkg::status_t          out_status_r;

  lfx_pkg::word_t            hist [lfx_pkg::HIST_LEN];
  lfx_pkg::word_t            fresh;
  lfx_pkg::word_t            shift_in;
  lfx_pkg::seed_t            pm_nxt;
  lfx_pkg::seed_t            in_seed;
  lfx_pkg::req_t             in_req;
  logic                      in_xfer;
  logic                      draw_go;
  logic                      shift_en;

  assign in_seed   = in_tdata[lfx_pkg::SEED_W-1:0];
  assign in_req    = lfx_pkg::req_t'(in_tuser[0]);
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_xfer   = in_tvalid && in_tready;
  assign draw_go   = in_xfer && (in_req == lfx_pkg::REQ_DRAW) && seeded_r;
  assign shift_en  = (state_r == ST_FILL) || draw_go;
  assign fresh     = hist[lfx_pkg::TAP_SHORT] + hist[lfx_pkg::TAP_LONG];
  assign shift_in  = (state_r == ST_FILL) ? lfx_pkg::word_t'(pm_nxt) : fresh;

  lfx_pm_step u_pm_step (
    .s     (seed_r),
    .s_nxt (pm_nxt)
  );

  for (genvar i = 0; i < lfx_pkg::HIST_LEN; i++) begin : g_chain
    if (i == lfx_pkg::HIST_LEN - 1) begin : g_head
      lfx_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (shift_in),
        .q        (hist[i])
      );
    end else begin : g_body
      lfx_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (hist[i+1]),
        .q        (hist[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_cnt_r  <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= '0;
            if (in_req == lfx_pkg::REQ_RESEED) begin
              if (in_seed == lfx_pkg::SEED_BAD) begin
                out_status_r <= lfx_pkg::STAT_REJECTED;
              end else begin
                out_status_r <= lfx_pkg::STAT_SEEDED;
                seed_r       <= in_seed;
                seeded_r     <= 1'b1;
                fill_cnt_r   <= '0;
                state_r      <= ST_FILL;
              end
            end else if (!seeded_r) begin
              out_status_r <= lfx_pkg::STAT_NOSEED;
            end else begin
              out_status_r <= lfx_pkg::STAT_DRAWN;
              out_value_r  <= fresh ^ hist[0];
            end
          end
        end
        ST_FILL: begin
          seed_r     <= pm_nxt;
          fill_cnt_r <= fill_cnt_r + lfx_pkg::CNT_W'(1);
          if (fill_cnt_r == lfx_pkg::FILL_LAST) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

  `LFX_ASSERT(a_fill_blocks_input, (state_r == ST_FILL) |-> !in_tready, "input taken during fill")
  `LFX_ASSERT(a_xfer_gives_result, in_xfer |=> out_valid_r, "transfer without a result")
  `LFX_ASSERT(a_fill_ends, (state_r == ST_FILL && fill_cnt_r == lfx_pkg::FILL_LAST) |=> (state_r == ST_IDLE), "fill overran")
  `LFX_ASSERT(a_seeded_sticks, !$fell(seeded_r), "seeded flag dropped")
  `LFX_ASSERT(a_fill_needs_seed, (state_r == ST_FILL) |-> seeded_r, "fill while unseeded")

endmodule
